// ----- src/variable_partition_allocator_unit_macros.svh -----
// assertion macros for the partition allocator
`ifndef VARIABLE_PARTITION_ALLOCATOR_UNIT_MACROS_SVH
`define VARIABLE_PARTITION_ALLOCATOR_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define VPA_ASSERT(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define VPA_ASSERT_IMP(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define VPA_ASSERT(label, cond, msg)
`define VPA_ASSERT_IMP(label, pre, post, msg)
`endif
`endif

// ----- src/vpa_pkg.sv -----
package vpa_pkg;
    localparam int MEM_SIZE_DEF  = 65536;
    localparam int MAX_PARTS_DEF = 32;
    localparam int TASK_W = 8;
    localparam int SIZE_W = 17;
    localparam int ADDR_W = 16;
    localparam int STAT_W = 2;

    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOSPACE = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOTASK  = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd3;

    localparam logic [1:0] POL_FIRST = 2'd0;
    localparam logic [1:0] POL_BEST  = 2'd1;
    localparam logic [1:0] POL_WORST = 2'd2;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;
endpackage

// ----- src/vpa_if.sv -----
interface vpa_req_if
    import vpa_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              opcode;
    logic [TASK_W-1:0] task_id;
    logic [SIZE_W-1:0] request_size;
    modport source (output valid, opcode, task_id, request_size, input ready);
    modport sink (input valid, opcode, task_id, request_size, output ready);
endinterface

interface vpa_rsp_if
    import vpa_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [ADDR_W-1:0] base_address;
    modport source (output valid, status, base_address, input ready);
    modport sink (input valid, status, base_address, output ready);
endinterface

// ----- src/variable_partition_allocator_unit.sv -----
// variable partition allocator
// req channel (sink): opcode, task_id, request_size; a beat is taken when
// valid and ready are high at a clock edge. rsp channel (source): status,
// base_address, one beat per request. cfg_we/cfg_wdata write fit_policy.
// the table lives in one memory; a single sequencer walks it one entry a
// cycle through one read port and one write port (read data registered).
// a scan reads the entries in order; a split then shifts the entries
// above the pick up by one (a read and a write state per moved entry),
// a free that merges shifts down by one or two (likewise per entry).
// longest case: a full-table best or worst fit scan, then a split at entry 0.
// ready is high only while the sequencer is idle; one request at a time.
// the response sits in an output register; a stalled receiver holds it
// and the block stays busy until the beat is taken.
// reset: entry 0 becomes one free partition of MEM_SIZE at address 0,
// count 1, fit_policy first fit. no clearing pass: entries above count
// are never read.
`include "variable_partition_allocator_unit_macros.svh"
module variable_partition_allocator_unit
    import vpa_pkg::*;
#(
    parameter int MEM_SIZE  = MEM_SIZE_DEF,
    parameter int MAX_PARTS = MAX_PARTS_DEF
)(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [1:0] cfg_wdata,
    vpa_req_if.sink    req,
    vpa_rsp_if.source  rsp
);
    localparam int IW = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;
    localparam int CW = $clog2(MAX_PARTS + 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SCAN  = 4'd1;
    localparam logic [3:0] S_DEC   = 4'd2;
    localparam logic [3:0] S_MVRD  = 4'd3;
    localparam logic [3:0] S_MVWR  = 4'd4;
    localparam logic [3:0] S_FIN   = 4'd5;
    localparam logic [3:0] S_RESP  = 4'd6;
    localparam logic [3:0] S_NBRD  = 4'd7;
    localparam logic [3:0] S_NBCK  = 4'd8;
    localparam logic [3:0] S_DNRD  = 4'd9;
    localparam logic [3:0] S_DNWR  = 4'd10;
    localparam logic [3:0] S_FIN2  = 4'd11;

    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [SIZE_W-1:0] size;
        logic              busy;
        logic [TASK_W-1:0] owner;
    } entry_t;

    entry_t mem [MAX_PARTS];
    entry_t rd_q;
    logic   init_done_reg;

    logic [3:0]        state_reg, state_next;
    logic [1:0]        pol_reg;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     ptr_reg, ptr_next;
    logic [CW-1:0]     scan_reg;
    logic              hit_reg, hit_next;
    logic [IW-1:0]     pick_reg, pick_next;
    entry_t            pe_reg, pe_next;
    entry_t            prev_reg, prev_next;
    logic              op_reg;
    logic [TASK_W-1:0] task_reg;
    logic [SIZE_W-1:0] want_reg;
    logic [STAT_W-1:0] st_reg, st_next;
    logic [ADDR_W-1:0] ba_reg, ba_next;
    logic              ov_reg, ov_next;
    logic [1:0]        ndel_reg, ndel_next;
    logic [CW-1:0]     scan_next;

    logic              we;
    logic [IW-1:0]     wa, ra;
    entry_t            wd;
    logic              rd_en;

    // entry 0 read as the reset partition until first written
    entry_t rd_eff;
    logic   rd0_reg;
    entry_t reset_e;
    always_comb
    begin
        reset_e.start = '0;
        reset_e.size  = SIZE_W'(MEM_SIZE);
        reset_e.busy  = 1'b0;
        reset_e.owner = '0;
        rd_eff = (rd0_reg && !init_done_reg) ? reset_e : rd_q;
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        if (rd_en)
        begin
            rd_q <= mem[ra];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_done_reg <= 1'b0;
            rd0_reg       <= 1'b0;
        end
        else
        begin
            if (we && wa == '0)
            begin
                init_done_reg <= 1'b1;
            end
            if (rd_en)
            begin
                rd0_reg <= (ra == '0);
            end
        end
    end

    logic fit;
    logic better;
    logic tfound;
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        ptr_next   = ptr_reg;
        scan_next  = scan_reg;
        hit_next   = hit_reg;
        pick_next  = pick_reg;
        pe_next    = pe_reg;
        prev_next  = prev_reg;
        st_next    = st_reg;
        ba_next    = ba_reg;
        ov_next    = ov_reg;
        ndel_next  = ndel_reg;
        we    = 1'b0;
        wa    = '0;
        wd    = rd_eff;
        rd_en = 1'b0;
        ra    = '0;
        fit    = !rd_eff.busy && rd_eff.size >= want_reg;
        better = (pol_reg == POL_BEST) ? (rd_eff.size < pe_reg.size) :
                 (pol_reg == POL_WORST) ? (rd_eff.size > pe_reg.size) : 1'b0;
        tfound = rd_eff.busy && rd_eff.owner == task_reg;
        case (state_reg)
            S_IDLE:
            begin
                // only start on an accepted beat; a held response keeps everything
                if (req.valid && !ov_reg)
                begin
                    rd_en = 1'b1;
                    ra = '0;
                    ptr_next = CW'(1);
                    scan_next = '0;
                    hit_next = 1'b0;
                    prev_next = reset_e;
                    prev_next.busy = 1'b1;
                    if (req.opcode == OP_ALLOC && req.request_size == '0)
                    begin
                        st_next = ST_NOSPACE;
                        ba_next = '0;
                        state_next = S_RESP;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                // rd_eff holds entry scan_reg; issue next read
                if (op_reg == OP_ALLOC)
                begin
                    if (fit && (!hit_reg || better))
                    begin
                        hit_next = 1'b1;
                        pick_next = IW'(scan_reg);
                        pe_next = rd_eff;
                    end
                end
                else if (tfound && !hit_reg)
                begin
                    hit_next = 1'b1;
                    pick_next = IW'(scan_reg);
                    pe_next = rd_eff;
                end
                if (!hit_reg)
                begin
                    if (!(op_reg == OP_FREE && tfound))
                    begin
                        prev_next = rd_eff;
                    end
                end
                // unused policy code behaves as first fit
                if ((hit_next && (op_reg == OP_FREE ||
                        (pol_reg != POL_BEST && pol_reg != POL_WORST)))
                        || ptr_reg >= count_reg)
                begin
                    state_next = S_DEC;
                end
                else
                begin
                    rd_en = 1'b1;
                    ra = IW'(ptr_reg);
                    scan_next = ptr_reg;
                    ptr_next = ptr_reg + CW'(1);
                end
            end
            S_DEC:
            begin
                if (!hit_reg)
                begin
                    st_next = (op_reg == OP_ALLOC) ? ST_NOSPACE : ST_NOTASK;
                    ba_next = '0;
                    state_next = S_RESP;
                end
                else if (op_reg == OP_ALLOC)
                begin
                    ba_next = pe_reg.start;
                    st_next = ST_OK;
                    if (pe_reg.size > want_reg)
                    begin
                        if (count_reg >= CW'(MAX_PARTS))
                        begin
                            st_next = ST_FULL;
                            ba_next = '0;
                            state_next = S_RESP;
                        end
                        else
                        begin
                            // shift entries pick+1..count-1 up by one, from the top
                            ptr_next = count_reg;
                            state_next = S_MVRD;
                        end
                    end
                    else
                    begin
                        state_next = S_FIN;
                    end
                end
                else
                begin
                    st_next = ST_OK;
                    ba_next = '0;
                    // free: merged entry in pe_reg, look at right neighbor
                    pe_next.busy = 1'b0;
                    pe_next.owner = '0;
                    ndel_next = '0;
                    if (pick_reg != '0 && !prev_reg.busy)
                    begin
                        pe_next.start = prev_reg.start;
                        pe_next.size = prev_reg.size + pe_reg.size;
                        pick_next = pick_reg - IW'(1);
                        ndel_next = 2'd1;
                    end
                    state_next = S_NBRD;
                end
            end
            S_MVRD:
            begin
                if (ptr_reg <= CW'(pick_reg) + CW'(1))
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    rd_en = 1'b1;
                    ra = IW'(ptr_reg - CW'(1));
                    state_next = S_MVWR;
                end
            end
            S_MVWR:
            begin
                we = 1'b1;
                wa = IW'(ptr_reg);
                wd = rd_eff;
                ptr_next = ptr_reg - CW'(1);
                state_next = S_MVRD;
            end
            S_FIN:
            begin
                we = 1'b1;
                wa = pick_reg;
                wd = pe_reg;
                wd.busy = 1'b1;
                wd.owner = task_reg;
                wd.size = want_reg;
                if (pe_reg.size > want_reg)
                begin
                    state_next = S_FIN2;
                end
                else
                begin
                    state_next = S_RESP;
                end
            end
            S_FIN2:
            begin
                we = 1'b1;
                wa = IW'(CW'(pick_reg) + CW'(1));
                wd.start = pe_reg.start + want_reg[ADDR_W-1:0];
                wd.size = pe_reg.size - want_reg;
                wd.busy = 1'b0;
                wd.owner = '0;
                count_next = count_reg + CW'(1);
                state_next = S_RESP;
            end
            S_NBRD:
            begin
                // read the entry after the original busy one
                if (CW'(pick_reg) + CW'(ndel_reg) + CW'(1) < count_reg)
                begin
                    rd_en = 1'b1;
                    ra = IW'(CW'(pick_reg) + CW'(ndel_reg) + CW'(1));
                    state_next = S_NBCK;
                end
                else
                begin
                    ptr_next = CW'(pick_reg) + CW'(1);
                    state_next = S_DNRD;
                end
            end
            S_NBCK:
            begin
                if (!rd_eff.busy)
                begin
                    pe_next.size = pe_reg.size + rd_eff.size;
                    ndel_next = ndel_reg + 2'd1;
                end
                ptr_next = CW'(pick_reg) + CW'(1);
                state_next = S_DNRD;
            end
            S_DNRD:
            begin
                // write merged entry first, then move tail down by ndel
                we = 1'b1;
                wa = pick_reg;
                wd = pe_reg;
                if (ndel_reg == '0 || ptr_reg + CW'(ndel_reg) >= count_reg)
                begin
                    count_next = count_reg - CW'(ndel_reg);
                    state_next = S_RESP;
                end
                else
                begin
                    rd_en = 1'b1;
                    ra = IW'(ptr_reg + CW'(ndel_reg));
                    state_next = S_DNWR;
                end
            end
            S_DNWR:
            begin
                we = 1'b1;
                wa = IW'(ptr_reg);
                wd = rd_eff;
                ptr_next = ptr_reg + CW'(1);
                state_next = S_DNRD;
            end
            S_RESP:
            begin
                ov_next = 1'b1;
                state_next = S_IDLE;
                if (ov_reg)
                begin
                    state_next = S_RESP;
                    ov_next = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (ov_reg && rsp.ready)
        begin
            ov_next = (state_reg == S_RESP) ? 1'b1 : 1'b0;
            if (state_reg == S_RESP)
            begin
                state_next = S_IDLE;
            end
        end
    end

    assign req.ready = (state_reg == S_IDLE) && !ov_reg;
    assign rsp.valid = ov_reg;
    assign rsp.status = st_reg;
    assign rsp.base_address = ba_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pol_reg   <= POL_FIRST;
            count_reg <= CW'(1);
            ov_reg    <= 1'b0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                pol_reg <= cfg_wdata;
            end
            state_reg <= (state_reg == S_IDLE && ov_reg) ? S_IDLE : state_next;
            count_reg <= count_next;
            ov_reg    <= ov_next;
            hit_reg   <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg  <= ptr_next;
        scan_reg <= scan_next;
        pick_reg <= pick_next;
        pe_reg   <= pe_next;
        prev_reg <= prev_next;
        st_reg   <= st_next;
        ba_reg   <= ba_next;
        ndel_reg <= ndel_next;
        if (req.valid && req.ready)
        begin
            op_reg   <= req.opcode;
            task_reg <= req.task_id;
            want_reg <= req.request_size;
        end
    end

    `VPA_ASSERT(a_count_range, count_reg >= CW'(1) && count_reg <= CW'(MAX_PARTS), "count out of range")
    `VPA_ASSERT_IMP(a_hold, rsp.valid && !rsp.ready, rsp.valid && $stable(rsp.status), "response dropped")
    `VPA_ASSERT(a_busy, !(req.ready && rsp.valid), "ready with pending response")
    `VPA_ASSERT_IMP(a_accept, req.valid && req.ready, state_reg != S_IDLE, "accept did not start")
endmodule

// ----- dv/variable_partition_allocator_unit_checker.sv -----
`timescale 1ns / 1ps
module variable_partition_allocator_unit_checker
    import vpa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [1:0] cfg_wdata,
    vpa_req_if         req,
    vpa_rsp_if         rsp,
    output int         fail_count,
    output int         pending
);
    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [ADDR_W-1:0] base_address;
    } alloc_reply_t;

    logic [ADDR_W-1:0] tbl_start [MAX_PARTS_DEF];
    logic [SIZE_W-1:0] tbl_size [MAX_PARTS_DEF];
    logic              tbl_busy [MAX_PARTS_DEF];
    logic [TASK_W-1:0] tbl_owner [MAX_PARTS_DEF];
    int                tbl_count;
    logic [1:0]        policy;
    alloc_reply_t      reply_q[$];

    function automatic int pick_free(logic [SIZE_W-1:0] want);
        int pick;
        pick = -1;
        for (int k = 0; k < tbl_count; k++)
        begin
            if (tbl_busy[k] || tbl_size[k] < want)
                continue;
            if (pick < 0)
            begin
                pick = k;
                if (policy != POL_BEST && policy != POL_WORST)
                    return pick;
            end
            else if (policy == POL_BEST && tbl_size[k] < tbl_size[pick])
                pick = k;
            else if (policy == POL_WORST && tbl_size[k] > tbl_size[pick])
                pick = k;
        end
        return pick;
    endfunction

    function automatic void drop_entry(int pos);
        for (int k = pos; k + 1 < tbl_count; k++)
        begin
            tbl_start[k] = tbl_start[k+1];
            tbl_size[k]  = tbl_size[k+1];
            tbl_busy[k]  = tbl_busy[k+1];
            tbl_owner[k] = tbl_owner[k+1];
        end
        tbl_count--;
    endfunction

    function automatic alloc_reply_t apply_request(logic op, logic [TASK_W-1:0] tid,
                                                   logic [SIZE_W-1:0] want);
        alloc_reply_t r;
        int p;
        r = '0;
        if (op == OP_ALLOC)
        begin
            p = (want == 0) ? -1 : pick_free(want);
            if (p < 0)
                r.status = ST_NOSPACE;
            else if (tbl_size[p] > want && tbl_count >= MAX_PARTS_DEF)
                r.status = ST_FULL;
            else
            begin
                if (tbl_size[p] > want)
                begin
                    for (int k = tbl_count; k > p + 1; k--)
                    begin
                        tbl_start[k] = tbl_start[k-1];
                        tbl_size[k]  = tbl_size[k-1];
                        tbl_busy[k]  = tbl_busy[k-1];
                        tbl_owner[k] = tbl_owner[k-1];
                    end
                    tbl_start[p+1] = tbl_start[p] + want[ADDR_W-1:0];
                    tbl_size[p+1]  = tbl_size[p] - want;
                    tbl_busy[p+1]  = 1'b0;
                    tbl_owner[p+1] = '0;
                    tbl_size[p]    = want;
                    tbl_count++;
                end
                tbl_busy[p]    = 1'b1;
                tbl_owner[p]   = tid;
                r.status       = ST_OK;
                r.base_address = tbl_start[p];
            end
        end
        else
        begin
            p = -1;
            for (int k = 0; k < tbl_count; k++)
                if (p < 0 && tbl_busy[k] && tbl_owner[k] == tid)
                    p = k;
            if (p < 0)
                r.status = ST_NOTASK;
            else
            begin
                tbl_busy[p]  = 1'b0;
                tbl_owner[p] = '0;
                if (p > 0 && !tbl_busy[p-1])
                begin
                    tbl_size[p-1] += tbl_size[p];
                    drop_entry(p);
                    p--;
                end
                if (p + 1 < tbl_count && !tbl_busy[p+1])
                begin
                    tbl_size[p] += tbl_size[p+1];
                    drop_entry(p + 1);
                end
                r.status = ST_OK;
            end
        end
        return r;
    endfunction

    assign pending = reply_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        alloc_reply_t want_r;
        if (!rst_n)
        begin
            for (int k = 0; k < MAX_PARTS_DEF; k++)
            begin
                tbl_start[k] = '0;
                tbl_size[k]  = '0;
                tbl_busy[k]  = 1'b0;
                tbl_owner[k] = '0;
            end
            tbl_size[0] = SIZE_W'(MEM_SIZE_DEF);
            tbl_count   = 1;
            policy      = POL_FIRST;
            reply_q.delete();
            fail_count  = 0;
        end
        else
        begin
            if (cfg_we)
                policy = cfg_wdata;
            if (req.valid && req.ready)
                reply_q.push_back(apply_request(req.opcode, req.task_id, req.request_size));
            if (rsp.valid && rsp.ready)
            begin
                if (reply_q.size() == 0)
                begin
                    $error("unexpected response beat");
                    fail_count++;
                end
                else
                begin
                    want_r = reply_q.pop_front();
                    if (rsp.status !== want_r.status)
                    begin
                        $error("status: expected %0d actual %0d", want_r.status, rsp.status);
                        fail_count++;
                    end
                    if (rsp.base_address !== want_r.base_address)
                    begin
                        $error("base_address: expected %0h actual %0h",
                               want_r.base_address, rsp.base_address);
                        fail_count++;
                    end
                end
            end
        end
    end
endmodule

// ----- dv/variable_partition_allocator_unit_test.sv -----
`timescale 1ns / 1ps
module variable_partition_allocator_unit_test;
    import vpa_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_we = 1'b0;
    logic [1:0] cfg_wdata = '0;
    int         fail_count;
    int         pending;
    int         idle_cycles = 0;
    bit         sending_done = 1'b0;

    vpa_req_if req ();
    vpa_rsp_if rsp ();

    always #1 clk = ~clk;

    variable_partition_allocator_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req),
        .rsp       (rsp)
    );

    variable_partition_allocator_unit_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .req        (req),
        .rsp        (rsp),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // mostly short gaps, now and then a long one, sometimes none at all
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 92)
            return $urandom_range(1, 4);
        return $urandom_range(20, 120);
    endfunction

    // one request beat; valid stays up until the block takes it and is
    // only dropped when a gap follows
    task automatic send_beat(logic op, logic [TASK_W-1:0] tid, logic [SIZE_W-1:0] sz);
        int gap;
        gap = gap_len();
        if (gap != 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid        <= 1'b1;
        req.opcode       <= op;
        req.task_id      <= tid;
        req.request_size <= sz;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
    endtask

    // policy writes only with nothing in flight, plus a margin for the sequencer
    task automatic set_policy(logic [1:0] pol);
        req.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4 * MAX_PARTS_DEF + 20) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= pol;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // random size: mostly small so the table fills up and splits happen
    function automatic logic [SIZE_W-1:0] pick_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return SIZE_W'($urandom_range(1, 4096));
        if (r < 85)
            return SIZE_W'($urandom_range(1, 20000));
        if (r < 95)
            return SIZE_W'($urandom_range(0, 65536));
        return SIZE_W'($urandom_range(65537, 131071));
    endfunction

    // a phase of random traffic: tasks drawn from a small pool so frees hit
    task automatic random_phase(int n);
        logic [TASK_W-1:0] tid;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                tid = TASK_W'($urandom_range(0, 255));
            else
                tid = TASK_W'($urandom_range(0, 11)) | ($urandom_range(0, 1) ? 8'hf0 : 8'h00);
            if ($urandom_range(0, 99) < 55)
                send_beat(OP_ALLOC, tid, pick_size());
            else
                send_beat(OP_FREE, tid, SIZE_W'($urandom_range(0, 131071)));
        end
    endtask

    // stimulus
    initial
    begin
        req.valid        <= 1'b0;
        req.opcode       <= OP_ALLOC;
        req.task_id      <= '0;
        req.request_size <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: zero size, oversize, exact whole memory, free of unknown task
        send_beat(OP_ALLOC, 8'd1, 17'd0);
        send_beat(OP_ALLOC, 8'd1, 17'd65537);
        send_beat(OP_ALLOC, 8'd1, 17'h1ffff);
        send_beat(OP_FREE, 8'd9, 17'h1ffff);
        send_beat(OP_ALLOC, 8'd255, 17'd65536);
        send_beat(OP_ALLOC, 8'd2, 17'd1);
        send_beat(OP_FREE, 8'd255, 17'd0);
        // holes of different sizes to tell the policies apart
        send_beat(OP_ALLOC, 8'd10, 17'd100);
        send_beat(OP_ALLOC, 8'd11, 17'd50);
        send_beat(OP_ALLOC, 8'd12, 17'd30);
        send_beat(OP_ALLOC, 8'd13, 17'd50);
        send_beat(OP_ALLOC, 8'd14, 17'd10);
        send_beat(OP_FREE, 8'd10, 17'd0);
        send_beat(OP_FREE, 8'd13, 17'd0);
        send_beat(OP_ALLOC, 8'd20, 17'd40);

        set_policy(POL_BEST);
        send_beat(OP_ALLOC, 8'd21, 17'd40);
        send_beat(OP_ALLOC, 8'd22, 17'd50);
        set_policy(POL_WORST);
        send_beat(OP_ALLOC, 8'd23, 17'd5);
        // free in the middle merges with both sides
        send_beat(OP_FREE, 8'd12, 17'd0);
        send_beat(OP_FREE, 8'd11, 17'd0);
        set_policy(2'd3);
        // fill the table with one-unit splits until table full shows up
        for (int i = 0; i < 34; i++)
            send_beat(OP_ALLOC, 8'd128, 17'd1);
        send_beat(OP_FREE, 8'd2, 17'd0);

        // random phases, each under a policy setting drawn at random
        for (int ph = 0; ph < 8; ph++)
        begin
            set_policy(2'($urandom_range(0, 3)));
            random_phase(140);
        end
        req.valid <= 1'b0;
        @(posedge clk);
        sending_done = 1'b1;
    end

    // response side: ready toggles with random stalls
    initial
    begin
        int stall;
        rsp.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = gap_len();
            if (stall != 0)
            begin
                rsp.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp.ready <= 1'b1;
            @(posedge clk);
        end
    end

    // watchdog and verdict
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
            if (sending_done && pending == 0)
            begin
                repeat (4 * MAX_PARTS_DEF + 20) @(posedge clk);
                if (fail_count == 0 && pending == 0)
                    $display("No mismatches found");
                else
                    $display("Mismatches found");
                $finish;
            end
        end
    end
endmodule
